[rtl/srde_pkg.sv]
`default_nettype none

package srde_pkg;

    localparam int MAX_BASE_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int RADIX_W    = 5;
    localparam int SYM_W      = 8;
    localparam int NUM_SYMS   = 16;
    localparam int ALPHA_W    = NUM_SYMS * SYM_W;
    localparam int CHUNK_W    = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = 2'd2;

    localparam logic [SYM_W-1:0]   SIGN_CHAR = 8'h2D;
    localparam logic [SYM_W-1:0]   PLUS_CHAR = 8'h2B;
    localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

    typedef struct packed {
        logic [ALPHA_W-1:0] alphabet;
        logic [RADIX_W-1:0] radix;
    } cfg_t;

    // radix is already capped at the max base
    function automatic logic alphabet_ok(input logic [ALPHA_W-1:0] alph,
                                         input logic [RADIX_W-1:0] r);
        logic             ok;
        logic [SYM_W-1:0] si;
        ok = (r >= MIN_RADIX);
        for (int i = 0; i < NUM_SYMS; i++)
        begin
            si = alph[i*SYM_W +: SYM_W];
            if (RADIX_W'(i) < r)
            begin
                if (si == '0 || si == SIGN_CHAR || si == PLUS_CHAR)
                    ok = 1'b0;
                for (int j = i + 1; j < NUM_SYMS; j++)
                begin
                    if (RADIX_W'(j) < r && alph[j*SYM_W +: SYM_W] == si)
                        ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

[rtl/signed_radix_digit_emitter_unit.sv]
// Signed integer to radix string converter.
// Input channel: value with value_valid / value_stall; an item is taken when
// value_valid is high and value_stall is low. Output channel: one character per
// item on symbol / last with symbol_valid / symbol_stall; last marks the final
// character of a value's run. A negative value starts with '-'.
// Config: cfg_we / cfg_index / cfg_data write alphabet_low (0), alphabet_high (1)
// and radix (2); write only while the block is idle. A bad alphabet drops items.
// Items pass through a two-entry queue to a sequential converter. The converter
// takes one item at a time: digits come from a shared restoring divider that
// handles 8 dividend bits per cycle, then a sign slot loads the '-' of a
// negative value, and the digits go out one per cycle while the output does
// not stall.
// Reset clears the config registers, the queue and the converter; the digit
// store is not cleared. A stall on the output holds the character in the
// output register; the queue keeps taking items until it fills.
`default_nettype none

module signed_radix_digit_emitter_unit #(
    parameter int MAX_BASE    = srde_pkg::MAX_BASE_DEF,
    parameter int VALUE_WIDTH = srde_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [srde_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [srde_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              value_valid,
    output logic                                   value_stall,
    input  wire logic [VALUE_WIDTH-1:0]            value,
    output logic                                   symbol_valid,
    input  wire logic                              symbol_stall,
    output logic [srde_pkg::SYM_W-1:0]             symbol,
    output logic                                   last
);

    localparam int RADIX_W = srde_pkg::RADIX_W;

    logic [srde_pkg::CFG_DATA_W-1:0] alpha_low_reg, alpha_low_next;
    logic [srde_pkg::CFG_DATA_W-1:0] alpha_high_reg, alpha_high_next;
    logic [RADIX_W-1:0]              radix_reg, radix_next;

    srde_pkg::cfg_t     cfg;
    logic               q_full, q_empty, q_push, q_pop;
    logic [VALUE_WIDTH:0] q_in, q_out;

    always_comb
    begin
        alpha_low_next  = alpha_low_reg;
        alpha_high_next = alpha_high_reg;
        radix_next      = radix_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                srde_pkg::CFG_ALPHA_LOW:  alpha_low_next  = cfg_data;
                srde_pkg::CFG_ALPHA_HIGH: alpha_high_next = cfg_data;
                srde_pkg::CFG_RADIX:      radix_next      = cfg_data[RADIX_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
            radix_reg      <= '0;
        end
        else
        begin
            alpha_low_reg  <= alpha_low_next;
            alpha_high_reg <= alpha_high_next;
            radix_reg      <= radix_next;
        end
    end

    always_comb
    begin
        cfg.alphabet = {alpha_high_reg, alpha_low_reg};
        cfg.radix    = (radix_reg > RADIX_W'(MAX_BASE)) ? RADIX_W'(MAX_BASE) : radix_reg;
    end

    srde_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .value_valid (value_valid),
        .value_stall (value_stall),
        .value       (value),
        .cfg         (cfg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    srde_queue #(
        .WIDTH (VALUE_WIDTH + 1),
        .DEPTH (srde_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    srde_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_BASE    (MAX_BASE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_empty      (q_empty),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .symbol_valid (symbol_valid),
        .symbol_stall (symbol_stall),
        .symbol       (symbol),
        .last         (last)
    );

endmodule

`default_nettype wire

[rtl/srde_front.sv]
`default_nettype none

module srde_front #(
    parameter int VALUE_WIDTH = srde_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   value_valid,
    output logic                        value_stall,
    input  wire logic [VALUE_WIDTH-1:0] value,
    input  wire srde_pkg::cfg_t         cfg,
    input  wire logic                   q_full,
    output logic                        q_push,
    output logic [VALUE_WIDTH:0]        q_data
);

    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   ok;

    always_comb
    begin
        neg = value[VALUE_WIDTH-1];
        mag = neg ? (~value + VALUE_WIDTH'(1)) : value;
        ok  = srde_pkg::alphabet_ok(cfg.alphabet, cfg.radix);
    end

    // items under a bad alphabet are taken and dropped
    assign value_stall = q_full;
    assign q_push      = value_valid && !q_full && ok;
    assign q_data      = {neg, mag};

endmodule

`default_nettype wire

[rtl/srde_queue.sv]
`default_nettype none

module srde_queue #(
    parameter int WIDTH = srde_pkg::VALUE_WIDTH_DEF + 1,
    parameter int DEPTH = srde_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/srde_back.sv]
`default_nettype none

module srde_back #(
    parameter int VALUE_WIDTH = srde_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_BASE    = srde_pkg::MAX_BASE_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire srde_pkg::cfg_t            cfg,
    input  wire logic                      q_empty,
    input  wire logic [VALUE_WIDTH:0]      q_data,
    output logic                           q_pop,
    output logic                           symbol_valid,
    input  wire logic                      symbol_stall,
    output logic [srde_pkg::SYM_W-1:0]     symbol,
    output logic                           last
);

    localparam int DIG_W   = $clog2(MAX_BASE);
    localparam int IDX_W   = $clog2(VALUE_WIDTH);
    localparam int CNT_W   = $clog2(VALUE_WIDTH + 1);
    localparam int CHUNK_W = srde_pkg::CHUNK_W;
    localparam int STEPS   = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int STEP_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int PAD_W   = STEPS * CHUNK_W;
    localparam int RADIX_W = srde_pkg::RADIX_W;
    localparam int SYM_W   = srde_pkg::SYM_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [PAD_W-1:0]  quot_reg, quot_next;
    logic [DIG_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic              out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]  symbol_reg, symbol_next;
    logic              last_reg, last_next;
    logic [DIG_W-1:0]  rd_data_reg;

    logic [DIG_W-1:0]   digit_store [VALUE_WIDTH];
    logic               store_we;
    logic [IDX_W-1:0]   rd_idx;
    logic [CNT_W-1:0]   cnt_dec;

    logic [CHUNK_W-1:0] chunk;
    logic [CHUNK_W-1:0] qbits;
    logic [RADIX_W-1:0] trial;
    logic [DIG_W-1:0]   rem_calc;
    logic [PAD_W-1:0]   quot_shift;
    logic               digit_done;
    logic               out_free;
    logic [SYM_W-1:0]   digit_sym;

    // restoring division, one chunk of the dividend per cycle
    always_comb
    begin
        chunk    = quot_reg[PAD_W-1 -: CHUNK_W];
        rem_calc = rem_reg;
        trial    = '0;
        qbits    = '0;
        for (int b = CHUNK_W - 1; b >= 0; b--)
        begin
            trial = RADIX_W'({rem_calc, chunk[b]});
            if (trial >= cfg.radix)
            begin
                trial    = trial - cfg.radix;
                qbits[b] = 1'b1;
            end
            rem_calc = trial[DIG_W-1:0];
        end
        quot_shift = (quot_reg << CHUNK_W) | PAD_W'(qbits);
    end

    assign digit_done = (state_reg == ST_DIV) && (step_reg == STEP_W'(STEPS - 1));
    assign store_we   = digit_done;
    assign out_free   = !out_valid_reg || !symbol_stall;
    assign q_pop      = (state_reg == ST_IDLE) && !q_empty;
    assign digit_sym  = cfg.alphabet[{rd_data_reg, 3'b000} +: SYM_W];

    always_comb
    begin
        state_next     = state_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        symbol_next    = symbol_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && symbol_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    quot_next  = PAD_W'(q_data[VALUE_WIDTH-1:0]);
                    neg_next   = q_data[VALUE_WIDTH];
                    rem_next   = '0;
                    step_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                quot_next = quot_shift;
                if (digit_done)
                begin
                    cnt_next  = cnt_reg + CNT_W'(1);
                    rem_next  = '0;
                    step_next = '0;
                    if (quot_shift == '0 || cnt_next == CNT_W'(VALUE_WIDTH))
                        state_next = ST_SIGN;
                end
                else
                begin
                    rem_next  = rem_calc;
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_SIGN:
            begin
                if (!neg_reg)
                    state_next = ST_EMIT;
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = srde_pkg::SIGN_CHAR;
                    last_next      = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = digit_sym;
                    last_next      = (cnt_reg == CNT_W'(1));
                    cnt_next       = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // read address follows the next count so the registered read data matches the current count
    assign cnt_dec = cnt_next - CNT_W'(1);
    assign rd_idx  = (cnt_next == '0) ? '0 : cnt_dec[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (store_we)
            digit_store[cnt_reg[IDX_W-1:0]] <= rem_calc;
        rd_data_reg <= digit_store[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        quot_reg   <= quot_next;
        rem_reg    <= rem_next;
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
        neg_reg    <= neg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign symbol_valid = out_valid_reg;
    assign symbol       = symbol_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

[rtl/srde_checker.sv]
`default_nettype none

module srde_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          symbol_valid,
    input wire logic                          symbol_stall,
    input wire logic [srde_pkg::SYM_W-1:0]    symbol,
    input wire logic                          last
);

    // sign never ends a run
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_valid && symbol == srde_pkg::SIGN_CHAR |-> !last)
        else $error("sign character flagged as last");

    // a valid alphabet holds no zero byte and no plus sign
    a_no_bad_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_valid |-> symbol != '0 && symbol != srde_pkg::PLUS_CHAR)
        else $error("forbidden symbol emitted");

    // a taken sign is never followed directly by another sign
    a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_valid && !symbol_stall && symbol == srde_pkg::SIGN_CHAR
        |=> !symbol_valid || symbol != srde_pkg::SIGN_CHAR)
        else $error("two signs in a row");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_valid && symbol_stall |=> symbol_valid && $stable(symbol) && $stable(last))
        else $error("stalled item changed");

endmodule

bind signed_radix_digit_emitter_unit srde_checker u_checker (.*);

`default_nettype wire

[verif/tb_signed_radix_digit_emitter_unit.sv]
`timescale 1ns / 1ps

module tb_signed_radix_digit_emitter_unit;

    localparam int VW            = srde_pkg::VALUE_WIDTH_DEF;
    localparam int SYM_W         = srde_pkg::SYM_W;
    localparam int RADIX_W       = srde_pkg::RADIX_W;
    localparam int CFG_IDX_W     = srde_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W    = srde_pkg::CFG_DATA_W;
    localparam int ALPHA_W       = srde_pkg::ALPHA_W;
    localparam int NUM_SYMS      = srde_pkg::NUM_SYMS;
    localparam int RANDOM_ITEMS  = 420;
    localparam int SETTLE_CYCLES = 600;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 4000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
    } char_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  value_valid = 1'b0;
    logic                  value_stall;
    logic [VW-1:0]         value = '0;
    logic                  symbol_valid;
    logic                  symbol_stall = 1'b0;
    logic [SYM_W-1:0]      symbol;
    logic                  last;

    signed_radix_digit_emitter_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .value_valid  (value_valid),
        .value_stall  (value_stall),
        .value        (value),
        .symbol_valid (symbol_valid),
        .symbol_stall (symbol_stall),
        .symbol       (symbol),
        .last         (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // register copies and converter state
    logic [CFG_DATA_W-1:0] alphabet_low_q  = '0;
    logic [CFG_DATA_W-1:0] alphabet_high_q = '0;
    logic [RADIX_W-1:0]    radix_q         = '0;
    logic [VW-1:0]         conv_magnitude  = '0;
    logic [3:0]            conv_digits [VW];
    int                    conv_count      = 0;

    logic [VW-1:0] values_to_send [$];
    char_t         pending_chars [$];
    char_t         got_char;

    int   errors       = 0;
    int   idle_cycles  = 0;
    bit   value_taken  = 1'b0;
    bit   idle_enabled = 1'b1;
    bit   quiet        = 1'b0;
    bit   hold_request = 1'b0;
    bit   hold_done    = 1'b0;
    int   send_gap     = 0;
    int   stall_left   = 0;
    int   hold_left    = 0;

    function automatic int symbols_in_use(input logic [RADIX_W-1:0] r);
        return (r > srde_pkg::MAX_BASE_DEF) ? srde_pkg::MAX_BASE_DEF : int'(r);
    endfunction

    // expected characters for one accepted value
    function automatic void convert_value(input logic [VW-1:0] v);
        logic [ALPHA_W-1:0] alph;
        logic [255:0]       seen;
        logic [SYM_W-1:0]   s;
        logic [VW-1:0]      mag;
        logic               neg;
        logic               ok;
        int                 used;
        int                 n;
        int                 d;
        alph = {alphabet_high_q, alphabet_low_q};
        used = symbols_in_use(radix_q);
        ok   = (used >= int'(srde_pkg::MIN_RADIX));
        seen = '0;
        for (int i = 0; i < used; i++)
        begin
            s = alph[i*SYM_W +: SYM_W];
            if (s == 8'h00 || s == srde_pkg::SIGN_CHAR || s == srde_pkg::PLUS_CHAR || seen[s])
                ok = 1'b0;
            seen[s] = 1'b1;
        end
        if (!ok)
            return;
        neg = v[VW-1];
        mag = neg ? -v : v;
        conv_magnitude = mag;
        n = 0;
        do
        begin
            conv_digits[n] = 4'(mag % used);
            mag = mag / used;
            n++;
        end
        while (mag != 0 && n < VW);
        conv_count = n;
        if (neg)
            pending_chars.push_back('{sym: srde_pkg::SIGN_CHAR, last: 1'b0});
        for (int k = n; k > 0; k--)
        begin
            d = conv_digits[k-1];
            pending_chars.push_back('{sym: alph[d*SYM_W +: SYM_W], last: (k == 1)});
        end
    endfunction

    function automatic logic [ALPHA_W-1:0] random_alphabet(input int used);
        logic [ALPHA_W-1:0] alph;
        logic [255:0]       taken;
        logic [SYM_W-1:0]   b;
        taken = '0;
        taken[8'h00] = 1'b1;
        taken[srde_pkg::SIGN_CHAR] = 1'b1;
        taken[srde_pkg::PLUS_CHAR] = 1'b1;
        for (int i = 0; i < NUM_SYMS; i++)
        begin
            if (i < used)
            begin
                do
                    b = 8'($urandom_range(1, 255));
                while (taken[b]);
                taken[b] = 1'b1;
            end
            else
            begin
                b = 8'($urandom);
            end
            alph[i*SYM_W +: SYM_W] = b;
        end
        return alph;
    endfunction

    function automatic logic [VW-1:0] random_value();
        logic [VW-1:0] v;
        case ($urandom_range(0, 5))
            0, 1:
                v = VW'($urandom);
            2, 3:
            begin
                v = VW'($urandom) >> $urandom_range(0, VW - 1);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            4:
            begin
                v = VW'($urandom_range(0, 40));
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       v = {1'b1, {(VW-1){1'b0}}};
                    1:       v = {1'b0, {(VW-1){1'b1}}};
                    2:       v = '1;
                    3:       v = '0;
                    default: v = VW'(1);
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            srde_pkg::CFG_ALPHA_LOW:  alphabet_low_q  = data;
            srde_pkg::CFG_ALPHA_HIGH: alphabet_high_q = data;
            srde_pkg::CFG_RADIX:      radix_q         = data[RADIX_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_alphabet(input logic [ALPHA_W-1:0] alph,
                                input logic [CFG_DATA_W-1:0] radix_word);
        write_reg(srde_pkg::CFG_ALPHA_LOW, alph[CFG_DATA_W-1:0]);
        write_reg(srde_pkg::CFG_ALPHA_HIGH, alph[ALPHA_W-1:CFG_DATA_W]);
        write_reg(srde_pkg::CFG_RADIX, radix_word);
    endtask

    // wait for every item to go through, then let dropped items clear the block
    task automatic drain_and_settle();
        @(negedge clk);
        while (values_to_send.size() != 0 || value_valid || pending_chars.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && (!value_valid || value_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                value_valid <= 1'b0;
            end
            else if (idle_enabled && !quiet && $urandom_range(0, 9) == 0)
            begin
                send_gap = $urandom_range(1, 13) - 1;
                value_valid <= 1'b0;
            end
            else if (values_to_send.size() != 0)
            begin
                value       <= values_to_send.pop_front();
                value_valid <= 1'b1;
            end
            else
            begin
                value_valid <= 1'b0;
            end
        end
    end

    // output receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                symbol_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                symbol_stall <= 1'b1;
            end
            else if (idle_enabled && !quiet && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                symbol_stall <= 1'b1;
            end
            else
            begin
                symbol_stall <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            value_taken <= value_valid && !value_stall;
            if (value_valid && !value_stall)
                convert_value(value);
            if (symbol_valid && !symbol_stall)
            begin
                if (pending_chars.size() == 0)
                begin
                    if (errors < 10)
                        $display("ERROR: unexpected item symbol=%h last=%b", symbol, last);
                    errors++;
                end
                else
                begin
                    got_char = pending_chars.pop_front();
                    if (symbol !== got_char.sym || last !== got_char.last)
                    begin
                        if (errors < 10)
                            $display("ERROR: symbol exp %h got %h, last exp %b got %b",
                                     got_char.sym, symbol, got_char.last, last);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (value_valid && !value_stall) || (symbol_valid && !symbol_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("signed_radix_digit_emitter_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [ALPHA_W-1:0]    alph;
        logic [CFG_DATA_W-1:0] radix_word;
        int                    used;
        int                    pos;
        int                    other;
        int                    n;
        int                    items_sent;
        bit                    broken;
        bit                    first;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // decimal, signs, extremes
        set_alphabet({"FEDCBA98", "76543210"}, 64'd10);
        values_to_send = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10,
                           32'h7FFF_FFFF, 32'h8000_0000, 32'd1000000000};
        drain_and_settle();

        // radix above the cap saturates to 16; extreme symbol bytes
        set_alphabet({64'h8F8E_8D8C_8B8A_8988, 64'h0706_0504_0302_01FF}, 64'd31);
        values_to_send = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h1234_5678};
        drain_and_settle();

        // binary: longest runs
        set_alphabet({"FEDCBA98", "76543210"}, 64'd2);
        values_to_send = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555};
        drain_and_settle();

        // invalid alphabets: nothing comes out
        set_alphabet({"FEDCBA98", "76543210"}, 64'd1);
        values_to_send = '{32'd77};
        drain_and_settle();
        write_reg(srde_pkg::CFG_RADIX, 64'd0);
        values_to_send = '{32'hFFFF_FF00};
        drain_and_settle();
        set_alphabet({"FEDCBA98", "765-3210"}, 64'd10);
        values_to_send = '{32'd12345};
        drain_and_settle();
        write_reg(srde_pkg::CFG_ALPHA_LOW, "7654+210");
        values_to_send = '{-32'sd321};
        drain_and_settle();
        write_reg(srde_pkg::CFG_ALPHA_LOW, 64'h3736_3534_3332_0030);
        values_to_send = '{32'd5};
        drain_and_settle();
        set_alphabet({"FEDCBA98", "76543213"}, 64'd8);
        values_to_send = '{32'd64};
        drain_and_settle();

        // forbidden bytes past the radix are harmless
        set_alphabet({"FEDCBA98", 64'h3736_3500_2D32_3130}, 64'd3);
        write_reg(CFG_SPARE, {$urandom, $urandom});
        values_to_send = '{-32'sd5, 32'd7};
        drain_and_settle();

        items_sent = 0;
        first = 1'b1;
        while (items_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       radix_word = 64'd2;
                1:       radix_word = 64'd16;
                2:       radix_word = 64'($urandom_range(17, 31));
                default: radix_word = 64'($urandom_range(2, 16));
            endcase
            used = symbols_in_use(radix_word[RADIX_W-1:0]);
            alph = random_alphabet(used);
            broken = !first && ($urandom_range(0, 7) == 0);
            if (broken)
            begin
                pos = $urandom_range(0, used - 1);
                other = (pos + 1 + $urandom_range(0, used - 2)) % used;
                case ($urandom_range(0, 4))
                    0:       alph[pos*SYM_W +: SYM_W] = srde_pkg::SIGN_CHAR;
                    1:       alph[pos*SYM_W +: SYM_W] = srde_pkg::PLUS_CHAR;
                    2:       alph[pos*SYM_W +: SYM_W] = 8'h00;
                    3:       alph[pos*SYM_W +: SYM_W] = alph[other*SYM_W +: SYM_W];
                    default: radix_word = 64'($urandom_range(0, 1));
                endcase
            end
            if ($urandom_range(0, 1))
                radix_word[CFG_DATA_W-1:RADIX_W] =
                    (CFG_DATA_W - RADIX_W)'({$urandom, $urandom});
            set_alphabet(alph, radix_word);
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_SPARE, {$urandom, $urandom});
            idle_enabled = ($urandom_range(0, 3) != 0);
            n = broken ? 6 : $urandom_range(20, 60);
            if (first)
            begin
                idle_enabled = 1'b1;
                n = 80;
            end
            for (int i = 0; i < n; i++)
                values_to_send.push_back(random_value());
            if (first)
                hold_request = 1'b1;
            first = 1'b0;
            if (!broken)
                items_sent += n;
            drain_and_settle();
        end

        // closing stretch with both sides always ready
        quiet = 1'b1;
        set_alphabet(random_alphabet(10), 64'd10);
        for (int i = 0; i < 40; i++)
            values_to_send.push_back(random_value());
        drain_and_settle();

        if (errors == 0)
            $display("signed_radix_digit_emitter_unit verification clean");
        else
            $display("signed_radix_digit_emitter_unit verification failed");
        $finish;
    end

endmodule
